>>> sv/flv_cls_pkg.sv
// ----------------------------------------------------------------------------
// flv_cls_pkg
// Shared types and constants for the FLV media tag classifier.
// ----------------------------------------------------------------------------
package flv_cls_pkg;

  // tag type codes
  localparam logic [7:0] TAG_AUDIO = 8'd8;
  localparam logic [7:0] TAG_VIDEO = 8'd9;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_MASK = 2'd2;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration reset values
  localparam logic [31:0] RUN_GAP_RST    = 32'd1000;
  localparam logic [15:0] VIDEO_MASK_RST = 16'h1080;
  localparam logic [15:0] AUDIO_MASK_RST = 16'h0400;

  // stream slots
  localparam int unsigned STREAMS   = 2;
  localparam logic        STRM_VIDEO = 1'b0;
  localparam logic        STRM_AUDIO = 1'b1;

  // media header sizes and packet-type byte for a media packet
  localparam logic [2:0] HDR_AUDIO  = 3'd2;
  localparam logic [2:0] HDR_VIDEO  = 3'd5;
  localparam logic [7:0] PKT_MEDIA  = 8'd1;
  localparam logic [3:0] FRAME_KEY  = 4'd1;

  // wrap offset kept as a count of 2^32 steps; ceiling is 2^63 - 2^33
  localparam int unsigned WRAP_W    = 31;
  localparam logic [WRAP_W-1:0] WRAP_CEIL = 31'h7FFF_FFFE;
  localparam int unsigned TS_W      = 63;
  localparam logic [31:0] RUN_MAX   = 32'hFFFF_FFFF;

  // classification of one tag header
  typedef struct packed {
    logic        ok;
    logic        video;
    logic        key;
    logic [2:0]  hsize;
    logic [23:0] cts;
  } cls_t;

  // timeline result for one accepted packet
  typedef struct packed {
    logic [TS_W-1:0] ts;
    logic [31:0]     run;
    logic            opened;
  } tl_res_t;

endpackage

>>> sv/flv_cls_decode.sv
// ----------------------------------------------------------------------------
// flv_cls_decode
// Classifies a tag header against the codec masks and the packet-type byte.
// ----------------------------------------------------------------------------
module flv_cls_decode (
  input  logic [7:0]          tag_type,
  input  logic [23:0]         tag_size,
  input  logic [39:0]         media_head,
  input  logic [15:0]         video_codec_mask,
  input  logic [15:0]         audio_format_mask,
  output flv_cls_pkg::cls_t   cls
);

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic        is_vid;
  logic        is_aud;
  logic        vid_ok;
  logic        aud_ok;

  assign b0 = media_head[39:32];
  assign b1 = media_head[31:24];
  assign is_vid = (tag_type == flv_cls_pkg::TAG_VIDEO);
  assign is_aud = (tag_type == flv_cls_pkg::TAG_AUDIO);

  // codec / format supported, header fits, packet is a media packet
  assign vid_ok = is_vid && video_codec_mask[b0[3:0]] && (tag_size >= 24'd5)
                  && (b1 == flv_cls_pkg::PKT_MEDIA);
  assign aud_ok = is_aud && audio_format_mask[b0[7:4]] && (tag_size >= 24'd2)
                  && (b1 == flv_cls_pkg::PKT_MEDIA);

  // rejected tags give all-zero fields
  always_comb begin
    cls = '0;
    if (vid_ok) begin
      cls.ok    = 1'b1;
      cls.video = 1'b1;
      cls.key   = (b0[7:4] == flv_cls_pkg::FRAME_KEY);
      cls.hsize = flv_cls_pkg::HDR_VIDEO;
      cls.cts   = media_head[23:0];
    end else if (aud_ok) begin
      cls.ok    = 1'b1;
      cls.hsize = flv_cls_pkg::HDR_AUDIO;
    end
  end

endmodule

>>> sv/flv_cls_timeline.sv
// ----------------------------------------------------------------------------
// flv_cls_timeline
// Per-stream timestamp extension across 32-bit wraps and run tracking.
// ----------------------------------------------------------------------------
module flv_cls_timeline (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  upd,
  input  logic                  strm,
  input  logic [31:0]           raw,
  input  logic [31:0]           gap_ms,
  output flv_cls_pkg::tl_res_t  res
);

  localparam int unsigned TS_W   = flv_cls_pkg::TS_W;
  localparam int unsigned WRAP_W = flv_cls_pkg::WRAP_W;
  localparam int unsigned NS     = flv_cls_pkg::STREAMS;

  // per-stream state
  logic [TS_W-1:0]   last_time_r [NS];
  logic [WRAP_W-1:0] wrap_k_r    [NS];
  logic [31:0]       run_r       [NS];
  logic              seen_r      [NS];
  logic              started_r   [NS];

  logic [TS_W-1:0]   lt;
  logic [WRAP_W-1:0] k;
  logic [TS_W-1:0]   ts0;
  logic [63:0]       lt64;
  logic              back;
  logic              wrap_ok;
  logic [WRAP_W-1:0] k_nxt;
  logic [31:0]       run_nxt;

  assign lt   = last_time_r[strm];
  assign k    = wrap_k_r[strm];
  assign ts0  = {k, raw};
  assign lt64 = {1'b0, lt};

  // backward jump beyond the gap, and whether it looks like a 32-bit wrap
  assign back = seen_r[strm] &&
                (({1'b0, ts0} + {32'd0, gap_ms}) < lt64);
  assign wrap_ok = ({31'd0, {1'b0, raw} + 33'h0_8000_0000} < lt64) &&
                   (({1'b0, ts0} + 64'h1_0000_0000 + {32'd0, gap_ms}) >= lt64) &&
                   (k < flv_cls_pkg::WRAP_CEIL);

  always_comb begin
    k_nxt      = k;
    run_nxt    = run_r[strm];
    res.opened = 1'b0;
    if (back) begin
      if (wrap_ok) begin
        k_nxt = k + 31'd1;
      end else begin
        k_nxt = '0;
        if (run_r[strm] != flv_cls_pkg::RUN_MAX) begin
          run_nxt = run_r[strm] + 32'd1;
        end
        res.opened = 1'b1;
      end
    end
    // first packet of the stream opens run zero
    if (!started_r[strm]) begin
      run_nxt    = '0;
      res.opened = 1'b1;
    end
    res.ts  = {k_nxt, raw};
    res.run = run_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        wrap_k_r[i]  <= '0;
        run_r[i]     <= '0;
        seen_r[i]    <= 1'b0;
        started_r[i] <= 1'b0;
      end
    end else if (upd) begin
      wrap_k_r[strm]  <= k_nxt;
      run_r[strm]     <= run_nxt;
      seen_r[strm]    <= 1'b1;
      started_r[strm] <= 1'b1;
    end
  end

  // last timestamp, only read once seen
  always_ff @(posedge clk) begin
    if (upd) begin
      last_time_r[strm] <= res.ts;
    end
  end

endmodule

>>> sv/flv_media_tag_classifier.sv
// ----------------------------------------------------------------------------
// flv_media_tag_classifier
// Classifies FLV tag headers and extends media timestamps per stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one tag header request per cycle while in_ready is high.
//   Output channel (out_valid/out_ready) gives one descriptor per request,
//   in order; a rejected tag gives accepted = 0 with all other fields zero.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once,
//   user-issued only while no request is in flight; not enforced by the block.
// Pipeline: input register, then the result register, which drives the
//   output. Throughput: 1 request per cycle while out_ready stays high;
//   the per-stream timeline state is read and written in the same cycle,
//   so consecutive requests of one stream follow without a bubble.
// Reset: synchronous active-low rst_n clears both pipeline valids, the
//   configuration registers to their defaults and all stream run state.
// Stall: when out_ready is low the result register holds; the input
//   register still takes one more request, after which in_ready drops.
// ----------------------------------------------------------------------------
module flv_media_tag_classifier (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [flv_cls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [flv_cls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_tag_type,
  input  logic [23:0] in_data_size,
  input  logic [31:0] in_raw_timestamp,
  input  logic [39:0] in_media_head,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_is_video,
  output logic        out_keyframe,
  output logic [62:0] out_timestamp_ms,
  output logic signed [23:0] out_composition_ms,
  output logic [31:0] out_run_index,
  output logic        out_new_run,
  output logic [23:0] out_payload_size,
  output logic [2:0]  out_media_header_size
);

  // configuration registers
  logic [31:0] run_gap_r;
  logic [15:0] video_mask_r;
  logic [15:0] audio_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_gap_r    <= flv_cls_pkg::RUN_GAP_RST;
      video_mask_r <= flv_cls_pkg::VIDEO_MASK_RST;
      audio_mask_r <= flv_cls_pkg::AUDIO_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flv_cls_pkg::CFG_RUN_GAP:    run_gap_r    <= cfg_wdata;
        flv_cls_pkg::CFG_VIDEO_MASK: video_mask_r <= cfg_wdata[15:0];
        flv_cls_pkg::CFG_AUDIO_MASK: audio_mask_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic advance;
  logic in_fire;
  logic s1_fire;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign s1_fire  = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  logic [7:0]  tag_type_r;
  logic [23:0] tag_size_r;
  logic [31:0] raw_ts_r;
  logic [39:0] media_head_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tag_type_r   <= in_tag_type;
      tag_size_r   <= in_data_size;
      raw_ts_r     <= in_raw_timestamp;
      media_head_r <= in_media_head;
    end
  end

  // classification
  flv_cls_pkg::cls_t cls;

  flv_cls_decode u_decode (
    .tag_type          (tag_type_r),
    .tag_size          (tag_size_r),
    .media_head        (media_head_r),
    .video_codec_mask  (video_mask_r),
    .audio_format_mask (audio_mask_r),
    .cls               (cls)
  );

  // per-stream timeline
  flv_cls_pkg::tl_res_t tl;
  logic strm;

  assign strm = cls.video ? flv_cls_pkg::STRM_VIDEO : flv_cls_pkg::STRM_AUDIO;

  flv_cls_timeline u_timeline (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (s1_fire && cls.ok),
    .strm       (strm),
    .raw        (raw_ts_r),
    .gap_ms     (run_gap_r),
    .res        (tl)
  );

  // result register
  logic        acc_r;
  logic        vid_r;
  logic        key_r;
  logic [62:0] ts_r;
  logic [23:0] cts_r;
  logic [31:0] run_r;
  logic        opened_r;
  logic [23:0] psize_r;
  logic [2:0]  hsize_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      acc_r    <= cls.ok;
      vid_r    <= cls.video;
      key_r    <= cls.key;
      cts_r    <= cls.cts;
      hsize_r  <= cls.hsize;
      ts_r     <= cls.ok ? tl.ts : '0;
      run_r    <= cls.ok ? tl.run : '0;
      opened_r <= cls.ok && tl.opened;
      psize_r  <= cls.ok ? (tag_size_r - {21'd0, cls.hsize}) : '0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_accepted          = acc_r;
  assign out_is_video          = vid_r;
  assign out_keyframe          = key_r;
  assign out_timestamp_ms      = ts_r;
  assign out_composition_ms    = cts_r;
  assign out_run_index         = run_r;
  assign out_new_run           = opened_r;
  assign out_payload_size      = psize_r;
  assign out_media_header_size = hsize_r;

endmodule

>>> sv/flv_cls_checker.sv
// ----------------------------------------------------------------------------
// flv_cls_checker
// Port-level checks on the classifier's result channel.
// ----------------------------------------------------------------------------
module flv_cls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_is_video,
  input logic        out_keyframe,
  input logic [62:0] out_timestamp_ms,
  input logic signed [23:0] out_composition_ms,
  input logic [31:0] out_run_index,
  input logic        out_new_run,
  input logic [23:0] out_payload_size,
  input logic [2:0]  out_media_header_size
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_timestamp_ms)
      && $stable(out_run_index) && $stable(out_accepted))
    else $error("result changed while stalled");

  // rejected tag carries no descriptor
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> !out_is_video && !out_keyframe && !out_new_run
      && out_timestamp_ms == 63'd0 && out_run_index == 32'd0
      && out_payload_size == 24'd0 && out_media_header_size == 3'd0)
    else $error("rejected tag with nonzero fields");

  // header size follows the stream kind
  a_hsize: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |->
      (out_is_video && out_media_header_size == flv_cls_pkg::HDR_VIDEO) ||
      (!out_is_video && out_media_header_size == flv_cls_pkg::HDR_AUDIO))
    else $error("media header size does not match stream");

  // audio has no composition time and no keyframe flag
  a_audio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted && !out_is_video |->
      out_composition_ms == 24'sd0 && !out_keyframe)
    else $error("audio descriptor with video fields");

endmodule

bind flv_media_tag_classifier flv_cls_checker u_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_accepted          (out_accepted),
  .out_is_video          (out_is_video),
  .out_keyframe          (out_keyframe),
  .out_timestamp_ms      (out_timestamp_ms),
  .out_composition_ms    (out_composition_ms),
  .out_run_index         (out_run_index),
  .out_new_run           (out_new_run),
  .out_payload_size      (out_payload_size),
  .out_media_header_size (out_media_header_size)
);
